### hw/rtl/rrcc_pkg.sv
package rrcc_pkg;

	localparam logic [1:0] KIND_CLEAR = 2'd0;
	localparam logic [1:0] KIND_ADD   = 2'd1;
	localparam logic [1:0] KIND_CHECK = 2'd2;

	localparam logic [2:0] VERDICT_COVERED   = 3'd0;
	localparam logic [2:0] VERDICT_WRONG_VIS = 3'd1;
	localparam logic [2:0] VERDICT_PARTIAL   = 3'd2;
	localparam logic [2:0] VERDICT_NONE      = 3'd3;
	localparam logic [2:0] VERDICT_SKIPPED   = 3'd4;
	localparam logic [2:0] VERDICT_STORED    = 3'd5;
	localparam logic [2:0] VERDICT_FULL      = 3'd6;

	localparam logic [2:0]  CLASS_UNKNOWN = 3'd4;
	localparam logic [3:0]  STAGE_NO_FILTER = 4'd8;
	localparam logic [3:0]  STAGE_RESET = 4'd8;
	localparam logic [31:0] REG_TOP = 32'hFFFF_FFFF;

	localparam int IN_DATA_W  = 104;
	localparam int OUT_DATA_W = 16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic walk_last;
		logic table_empty;
		logic out_free;
	} sts_t;

	typedef struct packed {
		logic [2:0]  cls;
		logic [31:0] space;
		logic [31:0] first;
		logic [31:0] last;
		logic [2:0]  vis;
	} entry_t;

endpackage

### hw/rtl/rrcc_ctrl.sv
module rrcc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic [1:0]       in_kind,
	input  logic             in_reserved,
	input  rrcc_pkg::sts_t   sts,
	output logic             s_tready,
	output rrcc_pkg::cmd_t   cmd
);

	rrcc_pkg::state_t state_q;
	rrcc_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrcc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			rrcc_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					if (in_kind == rrcc_pkg::KIND_CHECK) begin
						// A skipped resource or an empty table needs no walk.
						if (in_reserved || sts.table_empty) begin
							state_d = rrcc_pkg::ST_FINISH;
						end else begin
							state_d = rrcc_pkg::ST_WALK;
						end
					end else if (in_kind == rrcc_pkg::KIND_CLEAR ||
						in_kind == rrcc_pkg::KIND_ADD) begin
						state_d = rrcc_pkg::ST_FINISH;
					end
				end
			end
			rrcc_pkg::ST_WALK: begin
				if (sts.walk_last) begin
					state_d = rrcc_pkg::ST_DRAIN;
				end
			end
			rrcc_pkg::ST_DRAIN: begin
				state_d = rrcc_pkg::ST_FINISH;
			end
			rrcc_pkg::ST_FINISH: begin
				if (sts.out_free) begin
					state_d = rrcc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rrcc_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready   = (state_q == rrcc_pkg::ST_IDLE);
		cmd.load   = (state_q == rrcc_pkg::ST_IDLE) && s_tvalid;
		cmd.step   = (state_q == rrcc_pkg::ST_WALK);
		cmd.commit = (state_q == rrcc_pkg::ST_FINISH) && sts.out_free;
	end

endmodule

### hw/rtl/rrcc_dp.sv
module rrcc_dp #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [3:0]                        cfg_wdata,
	input  logic [rrcc_pkg::IN_DATA_W-1:0]    in_data,
	input  logic [1:0]                        in_kind,
	input  rrcc_pkg::cmd_t                    cmd,
	output rrcc_pkg::sts_t                    sts,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [rrcc_pkg::OUT_DATA_W-1:0]   m_tdata
);

	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	// Fields of the incoming item.
	logic [2:0]  in_cls;
	logic [31:0] in_space;
	logic [31:0] in_first;
	logic [31:0] in_count;
	logic        in_open;
	logic [2:0]  in_vis;
	logic        in_rsv;
	logic [32:0] in_sum;
	logic [31:0] in_last;

	assign in_cls   = in_data[2:0];
	assign in_space = in_data[34:3];
	assign in_first = in_data[66:35];
	assign in_count = in_data[98:67];
	assign in_open  = in_data[99];
	assign in_vis   = in_data[102:100];
	assign in_rsv   = in_data[103];

	// Last register, saturating at the top of the register range.
	assign in_sum = {1'b0, in_first} + {1'b0, in_count} - 33'd1;
	always_comb begin
		if (in_open) begin
			in_last = rrcc_pkg::REG_TOP;
		end else if (in_count == 32'd0) begin
			in_last = in_first;
		end else if (in_sum[32]) begin
			in_last = rrcc_pkg::REG_TOP;
		end else begin
			in_last = in_sum[31:0];
		end
	end

	// Latched item.
	logic [1:0]  kind_q;
	logic [2:0]  cls_q;
	logic [31:0] space_q;
	logic [31:0] first_q;
	logic [31:0] last_q;
	logic        open_q;
	logic [2:0]  vis_q;
	logic        rsv_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= in_kind;
			cls_q   <= (in_cls > rrcc_pkg::CLASS_UNKNOWN) ? rrcc_pkg::CLASS_UNKNOWN : in_cls;
			space_q <= in_space;
			first_q <= in_first;
			last_q  <= in_last;
			open_q  <= in_open;
			vis_q   <= in_vis;
			rsv_q   <= in_rsv;
		end
	end

	// Provider table and its walk.
	rrcc_pkg::entry_t table_mem [MAX_ENTRIES];
	rrcc_pkg::entry_t rd_s1;
	rrcc_pkg::entry_t wr_entry;
	logic             rd_v_s1;
	logic [IW-1:0]    idx_q;
	logic [CW-1:0]    count_q;
	logic             bad_q;
	logic [3:0]       stage_q;
	logic             good_q;
	logic             wrong_q;
	logic             part_q;
	logic             m_valid_q;
	logic [2:0]       verdict_q;
	logic             wr_en;
	logic             table_full;
	logic             set_bad;
	logic [2:0]       verdict_d;

	assign wr_entry.cls   = cls_q;
	assign wr_entry.space = space_q;
	assign wr_entry.first = first_q;
	assign wr_entry.last  = last_q;
	assign wr_entry.vis   = vis_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_mem[count_q[IW-1:0]] <= wr_entry;
		end
		if (cmd.step) begin
			rd_s1 <= table_mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= cmd.step;
			if (cmd.load) begin
				idx_q <= '0;
			end else if (cmd.step) begin
				idx_q <= idx_q + IW'(1);
			end
		end
	end

	// Compare one table entry against the latched resource.
	logic [31:0] cend;
	logic        hit;
	logic        covered;
	logic        overlap;
	logic        vis_ok;

	assign cend    = open_q ? first_q : last_q;
	assign hit     = (rd_s1.cls == cls_q) && (rd_s1.space == space_q);
	assign covered = (rd_s1.first <= first_q) && (rd_s1.last >= cend);
	assign overlap = !open_q && !covered && (rd_s1.first <= cend) && (first_q <= rd_s1.last);
	assign vis_ok  = (stage_q >= rrcc_pkg::STAGE_NO_FILTER) || (rd_s1.vis == 3'd0) ||
		({1'b0, rd_s1.vis} == stage_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			good_q  <= 1'b0;
			wrong_q <= 1'b0;
			part_q  <= 1'b0;
		end else if (cmd.load) begin
			good_q  <= 1'b0;
			wrong_q <= 1'b0;
			part_q  <= 1'b0;
		end else if (rd_v_s1 && hit) begin
			good_q  <= good_q | (covered & vis_ok);
			wrong_q <= wrong_q | (covered & ~vis_ok);
			part_q  <= part_q | overlap;
		end
	end

	assign table_full = (count_q == CW'(MAX_ENTRIES));

	always_comb begin
		verdict_d = rrcc_pkg::VERDICT_STORED;
		wr_en     = 1'b0;
		set_bad   = 1'b0;
		case (kind_q)
			rrcc_pkg::KIND_ADD: begin
				if (table_full) begin
					verdict_d = rrcc_pkg::VERDICT_FULL;
				end else begin
					wr_en = cmd.commit;
				end
			end
			rrcc_pkg::KIND_CHECK: begin
				if (rsv_q) begin
					verdict_d = rrcc_pkg::VERDICT_SKIPPED;
				end else if (good_q) begin
					verdict_d = rrcc_pkg::VERDICT_COVERED;
				end else begin
					set_bad = cmd.commit;
					if (wrong_q) begin
						verdict_d = rrcc_pkg::VERDICT_WRONG_VIS;
					end else if (part_q) begin
						verdict_d = rrcc_pkg::VERDICT_PARTIAL;
					end else begin
						verdict_d = rrcc_pkg::VERDICT_NONE;
					end
				end
			end
			default: begin
				verdict_d = rrcc_pkg::VERDICT_STORED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			bad_q     <= 1'b0;
			stage_q   <= rrcc_pkg::STAGE_RESET;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				stage_q <= cfg_wdata;
			end
			if (cmd.commit && kind_q == rrcc_pkg::KIND_CLEAR) begin
				count_q <= '0;
				bad_q   <= 1'b0;
			end else begin
				if (wr_en) begin
					count_q <= count_q + CW'(1);
				end
				if (set_bad) begin
					bad_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			verdict_q <= verdict_d;
		end
	end

	// Count and flag change only on a commit, so they stay valid for the waiting item.
	logic [CW+4:0] count_ext;
	assign count_ext = {5'd0, count_q};

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'd0, count_ext[4:0], bad_q, verdict_q};

	assign sts.walk_last   = ((CW'(idx_q) + CW'(1)) == count_q);
	assign sts.table_empty = (count_q == '0);
	assign sts.out_free    = !m_valid_q || m_tready;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES))
		else $error("provider count beyond table depth");

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!m_valid_q || m_tready))
		else $error("result overwritten before it was taken");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && kind_q == rrcc_pkg::KIND_CLEAR |=> count_q == '0 && !bad_q)
		else $error("clear left table or flag set");

	a_covered_keeps_flag: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && kind_q == rrcc_pkg::KIND_CHECK && good_q |=> bad_q == $past(bad_q))
		else $error("covered resource changed the incompatible flag");

endmodule

### hw/rtl/register_range_coverage_check.sv
// One item at a time. Clear, add, skipped checks and checks of an empty table go from
// acceptance straight to the finish state; other checks first walk the N providers
// held, then drain. Finish loads the result once any earlier one is taken; the next
// item is taken the cycle after, even while that result still waits.
// Reset empties the provider count, clears the incompatible flag and sets the stage
// register to 8; table contents are not cleared and hold nothing valid.
module register_range_coverage_check #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wen,
	input  logic [3:0]   cfg_wdata,   // stage visibility code
	input  logic         s_tvalid,
	output logic         s_tready,
	// reg_class, reg_space, first_register, reg_count, open_ended, visibility,
	// reserved_space
	input  logic [103:0] s_tdata,
	input  logic [1:0]   s_tuser,     // kind
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [15:0]  m_tdata      // verdict, incompatible flag, entries_held
);

	rrcc_pkg::cmd_t cmd;
	rrcc_pkg::sts_t sts;

	rrcc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.in_kind     (s_tuser),
		.in_reserved (s_tdata[103]),
		.sts         (sts),
		.s_tready    (s_tready),
		.cmd         (cmd)
	);

	rrcc_dp #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.in_data   (s_tdata),
		.in_kind   (s_tuser),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

### dv/coverage_verdict_checker.sv
`timescale 1ns / 1ps

module coverage_verdict_checker #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wen,
	input  logic [3:0]   cfg_wdata,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [103:0] s_tdata,
	input  logic [1:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [15:0]  m_tdata,
	output int           fail_count,
	output int           pending
);

	typedef struct packed {
		logic [2:0]  cls;
		logic [31:0] space;
		logic [31:0] first;
		logic [31:0] last;
		logic        open_end;
		logic [2:0]  vis;
	} provider_t;

	// Same layout as the low bits of m_tdata.
	typedef struct packed {
		logic [4:0] held;
		logic       incompatible;
		logic [2:0] verdict;
	} verdict_t;

	provider_t   providers [MAX_ENTRIES];
	logic [31:0] held;
	logic        incompatible;
	logic [3:0]  stage;
	verdict_t    pending_verdicts [$];
	verdict_t    want;
	logic        miss;

	function automatic logic [31:0] range_end(input logic [31:0] first, input logic [31:0] count);
		logic [32:0] sum;
		sum = {1'b0, first} + ((count == 32'd0) ? 33'd1 : {1'b0, count}) - 33'd1;
		return sum[32] ? rrcc_pkg::REG_TOP : sum[31:0];
	endfunction

	function automatic logic stage_allows(input logic [2:0] vis);
		if (stage >= rrcc_pkg::STAGE_NO_FILTER)
			return 1'b1;
		return vis == 3'd0 || {1'b0, vis} == stage;
	endfunction

	function automatic verdict_t predict_verdict(input logic [1:0] kind, input logic [103:0] data);
		logic [2:0]  cls;
		logic [31:0] space, first, count, rend, pend;
		logic        open_end, reserved, good, wrong, part, covered;
		logic [2:0]  vis;
		provider_t   p;
		verdict_t    res;
		int          i;
		cls      = (data[2:0] > rrcc_pkg::CLASS_UNKNOWN) ? rrcc_pkg::CLASS_UNKNOWN : data[2:0];
		space    = data[34:3];
		first    = data[66:35];
		count    = data[98:67];
		open_end = data[99];
		vis      = data[102:100];
		reserved = data[103];
		res.verdict = rrcc_pkg::VERDICT_STORED;
		case (kind)
			rrcc_pkg::KIND_CLEAR: begin
				held = 32'd0;
				incompatible = 1'b0;
			end
			rrcc_pkg::KIND_ADD: begin
				if (held >= MAX_ENTRIES) begin
					res.verdict = rrcc_pkg::VERDICT_FULL;
				end else begin
					p.cls      = cls;
					p.space    = space;
					p.first    = first;
					p.last     = open_end ? 32'd0 : range_end(first, count);
					p.open_end = open_end;
					p.vis      = vis;
					providers[held] = p;
					held = held + 32'd1;
				end
			end
			default: begin
				if (reserved) begin
					res.verdict = rrcc_pkg::VERDICT_SKIPPED;
				end else begin
					rend = open_end ? rrcc_pkg::REG_TOP : range_end(first, count);
					good = 1'b0;
					wrong = 1'b0;
					part = 1'b0;
					for (i = 0; i < held && i < MAX_ENTRIES; i++) begin
						p = providers[i];
						if (p.cls == cls && p.space == space) begin
							pend = p.open_end ? rrcc_pkg::REG_TOP : p.last;
							// An open-ended resource only needs its base inside a provider.
							if (open_end) begin
								covered = p.first <= first && (p.open_end || p.last >= first);
							end else begin
								covered = p.first <= first && pend >= rend;
								if (!covered && p.first <= rend && first <= pend)
									part = 1'b1;
							end
							if (covered) begin
								if (stage_allows(p.vis))
									good = 1'b1;
								else
									wrong = 1'b1;
							end
						end
					end
					if (good) begin
						res.verdict = rrcc_pkg::VERDICT_COVERED;
					end else begin
						incompatible = 1'b1;
						if (wrong)
							res.verdict = rrcc_pkg::VERDICT_WRONG_VIS;
						else if (part)
							res.verdict = rrcc_pkg::VERDICT_PARTIAL;
						else
							res.verdict = rrcc_pkg::VERDICT_NONE;
					end
				end
			end
		endcase
		res.incompatible = incompatible;
		res.held = held[4:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_verdicts.delete();
			held = 32'd0;
			incompatible = 1'b0;
			stage = rrcc_pkg::STAGE_RESET;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (cfg_wen)
				stage = cfg_wdata;
			// Retire first, so a result never pairs with the item taken at the same edge.
			if (m_tvalid && m_tready) begin
				if (pending_verdicts.size() == 0) begin
					$error("unexpected result item: m_tdata %h", m_tdata);
					fail_count <= fail_count + 1;
				end else begin
					want = pending_verdicts.pop_front();
					miss = 1'b0;
					if (m_tdata[2:0] !== want.verdict) begin
						$error("verdict: expected %0d, actual %0d", want.verdict, m_tdata[2:0]);
						miss = 1'b1;
					end
					if (m_tdata[3] !== want.incompatible) begin
						$error("incompatible flag: expected %0d, actual %0d",
							want.incompatible, m_tdata[3]);
						miss = 1'b1;
					end
					if (m_tdata[8:4] !== want.held) begin
						$error("entries_held: expected %0d, actual %0d", want.held, m_tdata[8:4]);
						miss = 1'b1;
					end
					if (miss)
						fail_count <= fail_count + 1;
				end
			end
			if (s_tvalid && s_tready && s_tuser inside {rrcc_pkg::KIND_CLEAR,
				rrcc_pkg::KIND_ADD, rrcc_pkg::KIND_CHECK})
				pending_verdicts.insert(pending_verdicts.size(),
					predict_verdict(s_tuser, s_tdata));
			pending <= pending_verdicts.size();
		end
	end

endmodule

### dv/register_range_coverage_check_test.sv
`timescale 1ns / 1ps

module register_range_coverage_check_test;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int TABLE_DEPTH = 16;
	localparam int ITEM_TARGET = 1100;

	logic         clk;
	logic         arst_n;
	logic         cfg_wen;
	logic [3:0]   cfg_wdata;
	logic         s_tvalid;
	logic         s_tready;
	logic [103:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [15:0]  m_tdata;

	int fail_count;
	int pending;
	int items_sent;
	int long_hold;
	bit tx_idle;
	bit rx_idle;

	// Providers stored so far, used to aim checks at real table entries.
	logic [2:0]  p_cls   [TABLE_DEPTH];
	logic [31:0] p_space [TABLE_DEPTH];
	logic [31:0] p_first [TABLE_DEPTH];
	logic [31:0] p_count [TABLE_DEPTH];
	int          n_prov;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	register_range_coverage_check #(
		.MAX_ENTRIES(TABLE_DEPTH)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	coverage_verdict_checker #(
		.MAX_ENTRIES(TABLE_DEPTH)
	) verdict_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.fail_count(fail_count),
		.pending   (pending)
	);

	function automatic logic [103:0] pack_item(input logic [2:0] cls, input logic [31:0] space,
			input logic [31:0] first, input logic [31:0] count, input logic open_end,
			input logic [2:0] vis, input logic rsv);
		return {rsv, vis, open_end, count, first, space, cls};
	endfunction

	function automatic logic [31:0] rand_space();
		logic [31:0] v;
		case ($urandom_range(0, 5))
			0, 1: v = 32'd0;
			2: v = 32'd1;
			3: v = 32'd2;
			4: v = rrcc_pkg::REG_TOP;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic logic [31:0] rand_first();
		logic [31:0] v;
		case ($urandom_range(0, 3))
			0: v = 32'd0;
			1: v = $urandom_range(0, 64);
			2: v = rrcc_pkg::REG_TOP - $urandom_range(0, 64);
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic logic [31:0] rand_count();
		logic [31:0] v;
		case ($urandom_range(0, 5))
			0: v = 32'd0;
			1: v = rrcc_pkg::REG_TOP;
			2: v = $urandom;
			default: v = $urandom_range(1, 16);
		endcase
		return v;
	endfunction

	task automatic send_item(input logic [1:0] kind, input logic [103:0] data);
		int gap;
		gap = tx_idle ? int'($urandom_range(0, 8)) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= data;
		do @(posedge clk); while (!s_tready);
		if (kind != KIND_UNUSED)
			items_sent++;
	endtask

	task automatic clear_table();
		send_item(rrcc_pkg::KIND_CLEAR, 104'({$urandom, $urandom, $urandom, $urandom}));
		n_prov = 0;
	endtask

	task automatic add_provider(input logic [2:0] cls, input logic [31:0] space,
			input logic [31:0] first, input logic [31:0] count, input logic open_end,
			input logic [2:0] vis);
		send_item(rrcc_pkg::KIND_ADD,
			pack_item(cls, space, first, count, open_end, vis, 1'($urandom)));
		if (n_prov < TABLE_DEPTH) begin
			p_cls[n_prov] = cls;
			p_space[n_prov] = space;
			p_first[n_prov] = first;
			p_count[n_prov] = count;
			n_prov++;
		end
	endtask

	task automatic check_range(input logic [2:0] cls, input logic [31:0] space,
			input logic [31:0] first, input logic [31:0] count, input logic open_end,
			input logic rsv);
		send_item(rrcc_pkg::KIND_CHECK,
			pack_item(cls, space, first, count, open_end, 3'($urandom), rsv));
	endtask

	task automatic random_provider();
		logic [2:0] cls;
		cls = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
		add_provider(cls, rand_space(), rand_first(), rand_count(), $urandom_range(0, 4) == 0,
			3'($urandom_range(0, 7)));
	endtask

	// The stage register may only change with the block idle. An unused-kind item
	// gives no result, so wait out the longest table walk after the last result.
	task automatic write_stage(input logic [3:0] code);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= code;
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic run_phase(input int n, input bit fill);
		int          nadd;
		int          j;
		int          r;
		logic [2:0]  cls;
		logic [31:0] first;
		logic [31:0] count;
		clear_table();
		nadd = fill ? TABLE_DEPTH + 2 : int'($urandom_range(1, TABLE_DEPTH + 2));
		repeat (nadd) random_provider();
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 3) begin
				send_item(KIND_UNUSED, 104'({$urandom, $urandom, $urandom, $urandom}));
			end else if (r < 5) begin
				clear_table();
			end else if (r < 9) begin
				random_provider();
			end else if (n_prov > 0 && r < 80) begin
				// Aim at a stored provider: exact, inside, starting below, or running past it.
				j = $urandom_range(0, n_prov - 1);
				case ($urandom_range(0, 3))
					0: begin
						first = p_first[j];
						count = p_count[j];
					end
					1: begin
						first = p_first[j] + $urandom_range(0, 3);
						count = $urandom_range(0, 4);
					end
					2: begin
						first = p_first[j] - 32'd1;
						count = $urandom_range(1, 6);
					end
					default: begin
						first = p_first[j] + $urandom_range(0, 2);
						count = p_count[j] + $urandom_range(0, 3);
					end
				endcase
				cls = (p_cls[j] >= rrcc_pkg::CLASS_UNKNOWN) ? 3'($urandom_range(4, 7)) : p_cls[j];
				check_range(cls, p_space[j], first, count, $urandom_range(0, 6) == 0,
					$urandom_range(0, 12) == 0);
			end else begin
				check_range(3'($urandom), rand_space(), rand_first(), rand_count(),
					1'($urandom), $urandom_range(0, 9) == 0);
			end
		end
	endtask

	initial begin : receiver
		int stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (long_hold > 0) begin
				m_tready <= 1'b0;
				repeat (long_hold) @(posedge clk);
				long_hold = 0;
			end
			stall = rx_idle ? int'($urandom_range(0, 8)) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin : stimulus
		int         phase;
		logic [3:0] stage_pick;
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = 4'd0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = rrcc_pkg::KIND_CLEAR;
		items_sent = 0;
		long_hold = 0;
		n_prov = 0;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, with the stage at its reset value first.
		check_range(3'd0, 32'd0, 32'd0, 32'd1, 1'b0, 1'b0);
		clear_table();
		add_provider(3'd0, 32'd0, 32'd0, 32'd0, 1'b0, 3'd0);
		add_provider(3'd1, rrcc_pkg::REG_TOP, 32'd10, 32'd5, 1'b0, 3'd3);
		add_provider(3'd2, 32'd5, 32'hFFFF_FFF0, rrcc_pkg::REG_TOP, 1'b0, 3'd7);
		add_provider(3'd3, 32'd1, 32'd100, 32'd0, 1'b1, 3'd1);
		add_provider(3'd7, 32'd2, 32'd0, 32'd100, 1'b0, 3'd0);
		check_range(3'd0, 32'd0, 32'd0, 32'd1, 1'b0, 1'b0);
		check_range(3'd1, rrcc_pkg::REG_TOP, 32'd12, 32'd10, 1'b0, 1'b0);
		check_range(3'd1, rrcc_pkg::REG_TOP, 32'd10, 32'd5, 1'b0, 1'b0);
		check_range(3'd1, rrcc_pkg::REG_TOP, 32'd12, 32'd0, 1'b1, 1'b0);
		check_range(3'd2, 32'd5, rrcc_pkg::REG_TOP, 32'd1, 1'b0, 1'b0);
		check_range(3'd3, 32'd1, 32'd200, 32'd0, 1'b1, 1'b0);
		check_range(3'd3, 32'd1, 32'd50, 32'd0, 1'b1, 1'b0);
		check_range(3'd5, 32'd2, 32'd5, 32'd3, 1'b0, 1'b0);
		check_range(3'd4, 32'd3, 32'd5, 32'd3, 1'b0, 1'b0);
		check_range(3'd1, rrcc_pkg::REG_TOP, 32'd10, 32'd5, 1'b0, 1'b1);
		send_item(KIND_UNUSED, pack_item(3'd7, rrcc_pkg::REG_TOP, rrcc_pkg::REG_TOP,
			rrcc_pkg::REG_TOP, 1'b1, 3'd7, 1'b1));
		write_stage(4'd3);
		check_range(3'd1, rrcc_pkg::REG_TOP, 32'd10, 32'd2, 1'b0, 1'b0);
		write_stage(4'd2);
		check_range(3'd1, rrcc_pkg::REG_TOP, 32'd10, 32'd2, 1'b0, 1'b0);
		write_stage(4'd0);
		check_range(3'd0, 32'd0, 32'd0, 32'd1, 1'b0, 1'b0);
		check_range(3'd1, rrcc_pkg::REG_TOP, 32'd10, 32'd2, 1'b0, 1'b0);
		write_stage(4'd15);
		check_range(3'd1, rrcc_pkg::REG_TOP, 32'd10, 32'd2, 1'b0, 1'b0);

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			case (phase)
				0: stage_pick = 4'd0;
				1: stage_pick = rrcc_pkg::STAGE_NO_FILTER;
				2: stage_pick = 4'd15;
				default: stage_pick = 4'($urandom_range(0, 15));
			endcase
			write_stage(stage_pick);
			tx_idle = $urandom_range(0, 3) != 0;
			rx_idle = $urandom_range(0, 3) != 0;
			// Hold results back while items keep coming, so the input stalls.
			if (phase == 1 || $urandom_range(0, 9) == 0) begin
				tx_idle = 1'b0;
				long_hold = 150 + $urandom_range(0, 100);
			end
			run_phase(40 + $urandom_range(0, 30), phase == 0);
			phase++;
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
